// ----- src/r2q_pkg.sv -----
// Shared widths, types and helpers for the rotation matrix to quaternion core.
package r2q_pkg;

	// Fixed-point format of entries and results
	localparam int FRAC_BITS = 14;
	localparam int EW        = 16;
	localparam int QW        = 16;

	// Signed working width for the trace and the radicands
	localparam int RADW = 19;
	// A positive radicand stays below 2^17
	localparam int RADU = 17;
	// Root width and the even-sized radicand word fed to the root unit
	localparam int SW   = (RADU + FRAC_BITS + 1) / 2;
	localparam int VW   = 2 * SW;
	// Sum or difference of two entries, and the scaled dividend magnitude
	localparam int NUMW = EW + 1;
	localparam int NW   = NUMW + FRAC_BITS - 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = 2;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	// Classified request between front and back
	typedef struct packed {
		branch_t                 br;
		logic                    degen;
		logic [RADU-1:0]         rad;
		logic signed [NUMW-1:0]  n0;
		logic signed [NUMW-1:0]  n1;
		logic signed [NUMW-1:0]  n2;
	} work_t;

	// Control carried alongside the divider lanes
	typedef struct packed {
		branch_t         br;
		logic            degen;
		logic [SW-1:0]   root;
	} tag_t;

	// One divider lane: sign, partial remainder, quotient, dividend bits left
	typedef struct packed {
		logic            neg;
		logic [SW-1:0]   rem;
		logic [NW-1:0]   quo;
		logic [NW-1:0]   dvd;
	} lane_t;

	// Clamp a signed magnitude to the result range
	function automatic logic signed [QW-1:0] sat_mag(input logic neg, input logic [NW-1:0] mag);
		logic [QW-1:0] low;
		low = mag[QW-1:0];
		if (neg) begin
			if (mag >= NW'(32768)) sat_mag = QW'(16'sh8000);
			else                   sat_mag = QW'(-low);
		end else begin
			if (mag > NW'(32767)) sat_mag = QW'(16'sh7fff);
			else                  sat_mag = low;
		end
	endfunction

endpackage

// ----- src/r2q_mat_if.sv -----
// Matrix request channel.
interface r2q_mat_if;
	logic                         valid;
	logic                         ready;
	logic signed [r2q_pkg::EW-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;

	modport source (output valid, e11, e12, e13, e21, e22, e23, e31, e32, e33, input ready);
	modport sink   (input valid, e11, e12, e13, e21, e22, e23, e31, e32, e33, output ready);
endinterface

// ----- src/r2q_quat_if.sv -----
// Quaternion result channel.
interface r2q_quat_if;
	logic                          valid;
	logic                          ready;
	logic signed [r2q_pkg::QW-1:0] qx, qy, qz, qw;
	logic [1:0]                    branch_taken;
	logic                          degenerate;

	modport source (output valid, qx, qy, qz, qw, branch_taken, degenerate, input ready);
	modport sink   (input valid, qx, qy, qz, qw, branch_taken, degenerate, output ready);
endinterface

// ----- src/r2q_front.sv -----
// Front end: picks the branch, forms the radicand and the three numerators.
module r2q_front (
	input  logic               clk,
	input  logic               arst_n,
	r2q_mat_if.sink            mat,
	output logic               push_valid,
	input  logic               push_ready,
	output r2q_pkg::work_t     push_work
);
	logic signed [r2q_pkg::RADW-1:0] a11, a22, a33, tr, rad;
	logic                             adv;
	r2q_pkg::work_t                   work_d;
	r2q_pkg::work_t                   work_s1;
	logic                             valid_s1;

	// Widen diagonal and form the trace
	assign a11 = r2q_pkg::RADW'(mat.e11);
	assign a22 = r2q_pkg::RADW'(mat.e22);
	assign a33 = r2q_pkg::RADW'(mat.e33);
	assign tr  = a11 + a22 + a33;

	// Classify the request
	always_comb begin
		work_d = '0;
		if (!tr[r2q_pkg::RADW-1] && (tr != '0)) begin
			work_d.br = r2q_pkg::BR_TRACE;
			rad       = tr + r2q_pkg::RADW'(1 << r2q_pkg::FRAC_BITS);
			work_d.n0 = r2q_pkg::NUMW'(mat.e23) - r2q_pkg::NUMW'(mat.e32);
			work_d.n1 = r2q_pkg::NUMW'(mat.e31) - r2q_pkg::NUMW'(mat.e13);
			work_d.n2 = r2q_pkg::NUMW'(mat.e12) - r2q_pkg::NUMW'(mat.e21);
		end else if (mat.e11 >= mat.e22 && mat.e11 >= mat.e33) begin
			work_d.br = r2q_pkg::BR_X;
			rad       = r2q_pkg::RADW'(1 << r2q_pkg::FRAC_BITS) + a11 - a22 - a33;
			work_d.n0 = r2q_pkg::NUMW'(mat.e12) + r2q_pkg::NUMW'(mat.e21);
			work_d.n1 = r2q_pkg::NUMW'(mat.e13) + r2q_pkg::NUMW'(mat.e31);
			work_d.n2 = r2q_pkg::NUMW'(mat.e23) - r2q_pkg::NUMW'(mat.e32);
		end else if (mat.e22 > mat.e33) begin
			work_d.br = r2q_pkg::BR_Y;
			rad       = r2q_pkg::RADW'(1 << r2q_pkg::FRAC_BITS) + a22 - a11 - a33;
			work_d.n0 = r2q_pkg::NUMW'(mat.e21) + r2q_pkg::NUMW'(mat.e12);
			work_d.n1 = r2q_pkg::NUMW'(mat.e32) + r2q_pkg::NUMW'(mat.e23);
			work_d.n2 = r2q_pkg::NUMW'(mat.e31) - r2q_pkg::NUMW'(mat.e13);
		end else begin
			work_d.br = r2q_pkg::BR_Z;
			rad       = r2q_pkg::RADW'(1 << r2q_pkg::FRAC_BITS) + a33 - a11 - a22;
			work_d.n0 = r2q_pkg::NUMW'(mat.e31) + r2q_pkg::NUMW'(mat.e13);
			work_d.n1 = r2q_pkg::NUMW'(mat.e32) + r2q_pkg::NUMW'(mat.e23);
			work_d.n2 = r2q_pkg::NUMW'(mat.e12) - r2q_pkg::NUMW'(mat.e21);
		end
		work_d.degen = rad[r2q_pkg::RADW-1] || (rad == '0);
		work_d.rad   = rad[r2q_pkg::RADU-1:0];
	end

	// Advance when the stage is empty or its request moves on
	assign adv       = !valid_s1 || push_ready;
	assign mat.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mat.valid) begin
			work_s1 <= work_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_work  = work_s1;
endmodule

// ----- src/r2q_queue.sv -----
// Short request queue between front and back.
module r2q_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  r2q_pkg::work_t     push_work,
	output logic               pop_valid,
	input  logic               pop_ready,
	output r2q_pkg::work_t     pop_work
);
	r2q_pkg::work_t          slot_q [r2q_pkg::QUEUE_DEPTH];
	logic [r2q_pkg::QAW-1:0] wptr_q, rptr_q;
	logic [r2q_pkg::QAW:0]   count_q;
	logic                    push, pop;

	assign push_ready = (count_q != (r2q_pkg::QAW+1)'(r2q_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_work   = slot_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_work;
		end
	end
endmodule

// ----- src/r2q_sqrt.sv -----
// Pipelined floored square root, one root bit per stage.
module r2q_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  r2q_pkg::work_t          in_work,
	output logic                    out_valid,
	output logic [r2q_pkg::SW-1:0]  out_root,
	output r2q_pkg::work_t          out_work
);
	localparam int SW = r2q_pkg::SW;
	localparam int VW = r2q_pkg::VW;

	logic                 vld_s  [SW];
	logic [SW:0]          rem_s  [SW];
	logic [SW-1:0]        root_s [SW];
	logic [VW-1:0]        v_s    [SW];
	r2q_pkg::work_t       work_s [SW];

	for (genvar i = 0; i < SW; i++) begin : g_stage
		logic                 vl_in;
		logic [SW:0]          rem_in;
		logic [SW-1:0]        root_in;
		logic [VW-1:0]        v_in;
		r2q_pkg::work_t       w_in;
		logic [SW+2:0]        acc, trial, diff;

		if (i == 0) begin : g_first
			assign vl_in   = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign v_in    = VW'({in_work.rad, {r2q_pkg::FRAC_BITS{1'b0}}});
			assign w_in    = in_work;
		end else begin : g_next
			assign vl_in   = vld_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign v_in    = v_s[i-1];
			assign w_in    = work_s[i-1];
		end

		// Bring down two radicand bits and try the next root bit
		assign acc   = {rem_in, v_in[VW-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff  = acc - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (acc >= trial) begin
					rem_s[i]  <= diff[SW:0];
					root_s[i] <= {root_in[SW-2:0], 1'b1};
				end else begin
					rem_s[i]  <= acc[SW:0];
					root_s[i] <= {root_in[SW-2:0], 1'b0};
				end
				v_s[i]    <= v_in << 2;
				work_s[i] <= w_in;
			end
		end
	end

	assign out_valid = vld_s[SW-1];
	assign out_root  = root_s[SW-1];
	assign out_work  = work_s[SW-1];
endmodule

// ----- src/r2q_div.sv -----
// Pipelined three-lane restoring divider, one quotient bit per stage.
module r2q_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  r2q_pkg::tag_t                  in_tag,
	input  logic signed [r2q_pkg::NUMW-1:0] in_n0,
	input  logic signed [r2q_pkg::NUMW-1:0] in_n1,
	input  logic signed [r2q_pkg::NUMW-1:0] in_n2,
	output logic                           out_valid,
	output r2q_pkg::tag_t                  out_tag,
	output r2q_pkg::lane_t                 out_lane [3]
);
	localparam int SW   = r2q_pkg::SW;
	localparam int NW   = r2q_pkg::NW;
	localparam int NUMW = r2q_pkg::NUMW;

	logic             vld_s  [NW];
	r2q_pkg::tag_t    tag_s  [NW];
	r2q_pkg::lane_t   lane_s [NW][3];
	r2q_pkg::lane_t   lane_0 [3];
	logic signed [NUMW-1:0] num [3];

	assign num[0] = in_n0;
	assign num[1] = in_n1;
	assign num[2] = in_n2;

	// Split each numerator into sign and scaled magnitude
	for (genvar k = 0; k < 3; k++) begin : g_init
		logic [NUMW-1:0] mag;
		assign mag = num[k][NUMW-1] ? NUMW'(-num[k]) : NUMW'(num[k]);
		always_comb begin
			lane_0[k].neg = num[k][NUMW-1];
			lane_0[k].rem = '0;
			lane_0[k].quo = '0;
			lane_0[k].dvd = {mag, {(r2q_pkg::FRAC_BITS-1){1'b0}}};
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic           vl_in;
		r2q_pkg::tag_t  t_in;

		if (i == 0) begin : g_first
			assign vl_in = in_valid;
			assign t_in  = in_tag;
		end else begin : g_next
			assign vl_in = vld_s[i-1];
			assign t_in  = tag_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i] <= t_in;
			end
		end

		for (genvar k = 0; k < 3; k++) begin : g_lane
			r2q_pkg::lane_t l_in;
			logic [SW:0]    acc, dd, diff;

			if (i == 0) begin : g_first
				assign l_in = lane_0[k];
			end else begin : g_next
				assign l_in = lane_s[i-1][k];
			end

			// Shift in one dividend bit and subtract the root when it fits
			assign acc  = {l_in.rem, l_in.dvd[NW-1]};
			assign dd   = {1'b0, t_in.root};
			assign diff = acc - dd;

			always_ff @(posedge clk) begin
				if (en) begin
					lane_s[i][k].neg <= l_in.neg;
					lane_s[i][k].dvd <= l_in.dvd << 1;
					if (acc >= dd) begin
						lane_s[i][k].rem <= diff[SW-1:0];
						lane_s[i][k].quo <= {l_in.quo[NW-2:0], 1'b1};
					end else begin
						lane_s[i][k].rem <= acc[SW-1:0];
						lane_s[i][k].quo <= {l_in.quo[NW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign out_tag   = tag_s[NW-1];
	assign out_lane  = lane_s[NW-1];
endmodule

// ----- src/r2q_back.sv -----
// Back end: root, divides, saturation and the output register.
module r2q_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  r2q_pkg::work_t     pop_work,
	r2q_quat_if.source         quat
);
	localparam int SW = r2q_pkg::SW;
	localparam int QW = r2q_pkg::QW;

	logic                  adv;
	logic                  sq_valid;
	logic [SW-1:0]         sq_root;
	r2q_pkg::work_t        sq_work;
	r2q_pkg::tag_t         dv_tag_in;
	logic                  dv_valid;
	r2q_pkg::tag_t         dv_tag;
	r2q_pkg::lane_t        dv_lane [3];
	logic signed [QW-1:0]  quo [3];
	logic signed [QW-1:0]  main;
	logic signed [QW-1:0]  qx_d, qy_d, qz_d, qw_d;

	logic                  valid_q;
	logic signed [QW-1:0]  qx_q, qy_q, qz_q, qw_q;
	logic [1:0]            br_q;
	logic                  degen_q;

	// Whole pipe moves when the output register can take a request
	assign adv       = !valid_q || quat.ready;
	assign pop_ready = adv;

	r2q_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (pop_valid),
		.in_work   (pop_work),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_work  (sq_work)
	);

	always_comb begin
		dv_tag_in.br    = sq_work.br;
		dv_tag_in.degen = sq_work.degen || (sq_root == '0);
		dv_tag_in.root  = sq_root;
	end

	r2q_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.in_tag    (dv_tag_in),
		.in_n0     (sq_work.n0),
		.in_n1     (sq_work.n1),
		.in_n2     (sq_work.n2),
		.out_valid (dv_valid),
		.out_tag   (dv_tag),
		.out_lane  (dv_lane)
	);

	// Saturate quotients and the halved root
	for (genvar k = 0; k < 3; k++) begin : g_sat
		assign quo[k] = r2q_pkg::sat_mag(dv_lane[k].neg, dv_lane[k].quo);
	end
	assign main = (dv_tag.root[SW-1:1] > (SW-1)'(32767)) ? QW'(16'sh7fff)
	                                                     : QW'(dv_tag.root[SW-1:1]);

	// Place the main component in its branch's slot
	always_comb begin
		unique case (dv_tag.br)
			r2q_pkg::BR_TRACE: begin
				qx_d = quo[0]; qy_d = quo[1]; qz_d = quo[2]; qw_d = main;
			end
			r2q_pkg::BR_X: begin
				qx_d = main;   qy_d = quo[0]; qz_d = quo[1]; qw_d = quo[2];
			end
			r2q_pkg::BR_Y: begin
				qx_d = quo[0]; qy_d = main;   qz_d = quo[1]; qw_d = quo[2];
			end
			r2q_pkg::BR_Z: begin
				qx_d = quo[0]; qy_d = quo[1]; qz_d = main;   qw_d = quo[2];
			end
			default: begin
				qx_d = '0;     qy_d = '0;     qz_d = '0;     qw_d = '0;
			end
		endcase
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dv_valid) begin
			br_q    <= dv_tag.br;
			degen_q <= dv_tag.degen;
			qx_q    <= dv_tag.degen ? '0 : qx_d;
			qy_q    <= dv_tag.degen ? '0 : qy_d;
			qz_q    <= dv_tag.degen ? '0 : qz_d;
			qw_q    <= dv_tag.degen ? '0 : qw_d;
		end
	end

	assign quat.valid        = valid_q;
	assign quat.qx           = qx_q;
	assign quat.qy           = qy_q;
	assign quat.qz           = qz_q;
	assign quat.qw           = qw_q;
	assign quat.branch_taken = br_q;
	assign quat.degenerate   = degen_q;
endmodule

// ----- src/rotation_matrix_to_quaternion_core.sv -----
// Top level of the rotation matrix to quaternion core.
//
//   channel | dir | contents
//   --------+-----+---------------------------------------------------------
//   mat     | in  | e11..e33, signed Q2.14 matrix entries
//   quat    | out | qx, qy, qz, qw (signed Q2.14), branch_taken, degenerate
//
// One request per cycle sustained while the output is taken; a request passes the
// front register, queue, 16 root stages, 30 divide stages and output register,
// stage counts at 14 fraction bits set by the bit-per-stage root and divider.
// Reset clears only valid and queue state; there is no clearing pass.
// A stalled output freezes the back pipeline; the queue lets the front keep
// taking requests until it fills.
module rotation_matrix_to_quaternion_core (
	input  logic        clk,
	input  logic        arst_n,
	r2q_mat_if.sink     mat,
	r2q_quat_if.source  quat
);
	logic             push_valid, push_ready;
	r2q_pkg::work_t   push_work;
	logic             pop_valid, pop_ready;
	r2q_pkg::work_t   pop_work;

	r2q_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat        (mat),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_work  (push_work)
	);

	r2q_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_work  (push_work),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_work   (pop_work)
	);

	r2q_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_work  (pop_work),
		.quat      (quat)
	);
endmodule
